FILE: src/ftsr_pkg.sv
// Shared widths, defaults and the walk control bundle of the triangle span rasterizer.
package ftsr_pkg;

  // Field widths of the request and span channels
  localparam int unsigned X_W     = 10;
  localparam int unsigned Y_W     = 5;
  localparam int unsigned PAINT_W = 32;

  // Signed vertex differences
  localparam int unsigned DX_W   = X_W + 1;
  localparam int unsigned DY_W   = Y_W + 1;
  localparam int unsigned PROD_W = DX_W + DY_W;

  // Integer bits above the fraction: numerator/slope, and edge accumulator
  localparam int unsigned NUM_INT_W = 18;
  localparam int unsigned ACC_INT_W = 24;

  // Parameter defaults
  localparam int unsigned TILE_ROWS_DEF     = 32;
  localparam int unsigned TILE_COLUMNS_DEF  = 1024;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // One edge walk, handed from the sequencer to the span generator
  typedef struct packed {
    logic               load;
    logic               upward;
    logic               final_walk;
    logic [Y_W-1:0]     row_first;
    logic [Y_W-1:0]     row_last;
    logic [X_W-1:0]     x_first;
    logic [PAINT_W-1:0] paint;
  } walk_ctl_t;

endpackage

FILE: src/ftsr_divider.sv
// Shared signed fixed-point divider, two quotient bits per cycle, truncating toward zero.
module ftsr_divider #(
  parameter int unsigned FRACTION_BITS = ftsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  logic signed [FRACTION_BITS+ftsr_pkg::NUM_INT_W-1:0] num_i,
  input  logic signed [ftsr_pkg::DY_W-1:0]               den_i,
  output logic                                           done_o,
  output logic signed [FRACTION_BITS+ftsr_pkg::NUM_INT_W-1:0] quo_o
);

  localparam int unsigned NUMW     = FRACTION_BITS + ftsr_pkg::NUM_INT_W;
  localparam int unsigned QW       = NUMW - 1;
  localparam int unsigned STEPS    = (QW + 1) / 2;
  localparam int unsigned PW       = 2 * STEPS;
  localparam int unsigned CNTW     = $clog2(STEPS + 1);
  localparam int unsigned DW       = ftsr_pkg::Y_W;
  localparam int unsigned DY_W_LOC = ftsr_pkg::DY_W;

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [PW-1:0]   sh_q, sh_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q;
  logic            neg_q, zero_q;

  logic [NUMW-1:0]    num_mag;
  logic [DY_W_LOC-1:0] den_mag;
  logic [NUMW-1:0]    quo_mag;

  // Operand magnitudes
  always_comb begin
    num_mag = num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
    den_mag = den_i[DY_W_LOC-1] ? DY_W_LOC'(-den_i) : DY_W_LOC'(den_i);
  end

  // Two restoring steps per cycle on a narrow remainder
  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [PW-1:0] s;
    r = rem_q;
    s = sh_q;
    for (int i = 0; i < 2; i++) begin
      t = {r, s[PW-1]};
      s = s << 1;
      if (t >= {1'b0, den_q}) begin
        t    = t - {1'b0, den_q};
        s[0] = 1'b1;
      end
      r = t[DW-1:0];
    end
    rem_d = r;
    sh_d  = s;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q   <= PW'(num_mag[QW-1:0]);
      rem_q  <= '0;
      den_q  <= den_mag[DW-1:0];
      neg_q  <= num_i[NUMW-1] ^ den_i[DY_W_LOC-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign quo_mag = NUMW'(sh_q);
  assign quo_o   = zero_q ? '0 : (neg_q ? signed'(-quo_mag) : signed'(quo_mag));
  assign done_o  = done_q;

  // A new division never starts while one is running
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

  // Done follows the final iteration
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == CNTW'(1) && !start_i |=> done_o && !busy_q)
    else $error("divider did not finish");

endmodule

FILE: src/ftsr_span_gen.sv
// Edge walker: steps two Q-format edges one row per cycle while the output is not stalled, and registers each span.
module ftsr_span_gen #(
  parameter int unsigned TILE_COLUMNS  = ftsr_pkg::TILE_COLUMNS_DEF,
  parameter int unsigned FRACTION_BITS = ftsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  ftsr_pkg::walk_ctl_t                                 ctl_i,
  input  logic signed [FRACTION_BITS+ftsr_pkg::NUM_INT_W-1:0] slope_l_i,
  input  logic signed [FRACTION_BITS+ftsr_pkg::NUM_INT_W-1:0] slope_r_i,
  output logic                                                busy_o,
  output logic                                                out_valid_o,
  input  logic                                                out_stall_i,
  output logic [ftsr_pkg::Y_W-1:0]                            row_o,
  output logic [ftsr_pkg::X_W-1:0]                            x_start_o,
  output logic [ftsr_pkg::X_W-1:0]                            x_end_o,
  output logic [ftsr_pkg::PAINT_W-1:0]                        span_colour_o,
  output logic                                                last_o
);

  localparam int unsigned AW = FRACTION_BITS + ftsr_pkg::ACC_INT_W;
  localparam int unsigned IW = ftsr_pkg::ACC_INT_W;
  localparam int unsigned CW = $clog2(TILE_COLUMNS);
  localparam int unsigned XW = ftsr_pkg::X_W;
  localparam int unsigned YW = ftsr_pkg::Y_W;

  logic                        busy_q, ov_q;
  logic                        up_q, final_q;
  logic [YW-1:0]               row_q, end_q;
  logic [ftsr_pkg::PAINT_W-1:0] paint_q;
  logic signed [AW-1:0]        acc_l_q, acc_r_q, sl_l_q, sl_r_q;

  logic signed [AW-1:0] start_acc;
  logic [CW-1:0]        c1, c2, lo, hi;
  logic                 at_end, advance, empty_walk;

  // Edge position to column: negative gives zero, beyond the tile clamps
  function automatic logic [CW-1:0] to_col(input logic signed [AW-1:0] acc);
    logic [IW-1:0] ip;
    ip = acc[AW-1:FRACTION_BITS];
    if (acc[AW-1]) return '0;
    else if (ip > IW'(TILE_COLUMNS - 1)) return CW'(TILE_COLUMNS - 1);
    else return ip[CW-1:0];
  endfunction

  // Span of the current row
  always_comb begin
    c1         = to_col(acc_l_q);
    c2         = to_col(acc_r_q);
    lo         = (c1 < c2) ? c1 : c2;
    hi         = (c1 < c2) ? c2 : c1;
    at_end     = (row_q == end_q);
    advance    = busy_q && (!ov_q || !out_stall_i);
    start_acc  = signed'(AW'(ctl_i.x_first) << FRACTION_BITS);
    empty_walk = ctl_i.upward ? (ctl_i.row_first < ctl_i.row_last)
                              : (ctl_i.row_first > ctl_i.row_last);
  end

  // Control: walk busy and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        busy_q <= !empty_walk;
      end else if (advance && at_end) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Edge accumulators and walk bounds
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      up_q    <= ctl_i.upward;
      final_q <= ctl_i.final_walk;
      row_q   <= ctl_i.row_first;
      end_q   <= ctl_i.row_last;
      paint_q <= ctl_i.paint;
      acc_l_q <= start_acc;
      acc_r_q <= start_acc;
      sl_l_q  <= AW'(slope_l_i);
      sl_r_q  <= AW'(slope_r_i);
    end else if (advance && !at_end) begin
      if (up_q) begin
        row_q   <= row_q - 1'b1;
        acc_l_q <= acc_l_q - sl_l_q;
        acc_r_q <= acc_r_q - sl_r_q;
      end else begin
        row_q   <= row_q + 1'b1;
        acc_l_q <= acc_l_q + sl_l_q;
        acc_r_q <= acc_r_q + sl_r_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      row_o         <= row_q;
      x_start_o     <= XW'(lo);
      x_end_o       <= XW'(hi);
      span_colour_o <= paint_q;
      last_o        <= final_q && at_end;
    end
  end

  assign out_valid_o = ov_q;
  assign busy_o      = busy_q;

  // A walk is only loaded once the previous one is done
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |-> !busy_q) else $error("walk loaded while busy");

  // Span ends are ordered
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> x_start_o <= x_end_o) else $error("span ends out of order");

endmodule

FILE: src/filled_triangle_span_rasterizer_unit.sv
// Top level: request capture, slope sequencer, shared divider and span generator.
//
// Takes one triangle request (vertices sorted by row, colour, fill flag) on the
// input channel and sends horizontal spans on the output channel, the final one
// with last_o set. A request with fill_i low produces no span.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. in_stall_o is high from acceptance until the last span of the
// request has been loaded into the output register; the next request may be
// taken while that span still waits there.
// Edge slopes come from one shared divider that retires two quotient bits per
// cycle. A flat-top or flat-bottom triangle needs two divisions, a general
// triangle a multiply step and five divisions (split column plus two slopes
// per half). Spans then leave one per cycle while out_stall_i is low. When
// out_stall_i is high the walk holds with the span in the output register.
// Reset clears the sequencer, the walk busy flag and the output valid flag;
// a span still waiting in the output register is dropped.
module filled_triangle_span_rasterizer_unit #(
  parameter int unsigned TILE_ROWS     = ftsr_pkg::TILE_ROWS_DEF,
  parameter int unsigned TILE_COLUMNS  = ftsr_pkg::TILE_COLUMNS_DEF,
  parameter int unsigned FRACTION_BITS = ftsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ftsr_pkg::X_W-1:0]      ax_i,
  input  logic [ftsr_pkg::Y_W-1:0]      ay_i,
  input  logic [ftsr_pkg::X_W-1:0]      bx_i,
  input  logic [ftsr_pkg::Y_W-1:0]      by_i,
  input  logic [ftsr_pkg::X_W-1:0]      cx_i,
  input  logic [ftsr_pkg::Y_W-1:0]      cy_i,
  input  logic [ftsr_pkg::PAINT_W-1:0]  paint_i,
  input  logic                          fill_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ftsr_pkg::Y_W-1:0]      row_o,
  output logic [ftsr_pkg::X_W-1:0]      x_start_o,
  output logic [ftsr_pkg::X_W-1:0]      x_end_o,
  output logic [ftsr_pkg::PAINT_W-1:0]  span_colour_o,
  output logic                          last_o
);

  localparam int unsigned NUMW = FRACTION_BITS + ftsr_pkg::NUM_INT_W;
  localparam int unsigned XW   = ftsr_pkg::X_W;
  localparam int unsigned YW   = ftsr_pkg::Y_W;
  localparam int unsigned DXW  = ftsr_pkg::DX_W;
  localparam int unsigned DYW  = ftsr_pkg::DY_W;
  localparam int unsigned PRW  = ftsr_pkg::PROD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_OFF, S_L1, S_R1, S_W1, S_L2, S_R2, S_W2
  } state_e;

  typedef enum logic [1:0] {
    M_FLAT_BOTTOM, M_FLAT_TOP, M_SPLIT
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_in;
  logic   issued_q, issued_d;

  logic [XW-1:0]               ax_q, bx_q, cx_q, ax_c, bx_c, cx_c;
  logic [YW-1:0]               ay_q, by_q, cy_q, ay_c, by_c, cy_c;
  logic [ftsr_pkg::PAINT_W-1:0] paint_q;

  logic signed [DXW-1:0]  dx_ba, dx_ca, dx_cb;
  logic signed [DYW-1:0]  dy_ba, dy_ca, dy_cb;
  logic signed [PRW-1:0]  prod_q;
  logic signed [NUMW-1:0] q_ba, q_ca, q_cb, q_prod, q_low_r;
  logic signed [NUMW-1:0] off_q, slope_l_q, slope_r_q;

  logic                   accept, div_state;
  logic                   div_start, div_done;
  logic signed [NUMW-1:0] div_num, div_quo;
  logic signed [DYW-1:0]  div_den;

  ftsr_pkg::walk_ctl_t walk_ctl;
  logic                sg_busy;

  // Clamp the request to the tile and classify it
  always_comb begin
    ax_c = (32'(ax_i) > TILE_COLUMNS - 1) ? XW'(TILE_COLUMNS - 1) : ax_i;
    bx_c = (32'(bx_i) > TILE_COLUMNS - 1) ? XW'(TILE_COLUMNS - 1) : bx_i;
    cx_c = (32'(cx_i) > TILE_COLUMNS - 1) ? XW'(TILE_COLUMNS - 1) : cx_i;
    ay_c = (32'(ay_i) > TILE_ROWS - 1) ? YW'(TILE_ROWS - 1) : ay_i;
    by_c = (32'(by_i) > TILE_ROWS - 1) ? YW'(TILE_ROWS - 1) : by_i;
    cy_c = (32'(cy_i) > TILE_ROWS - 1) ? YW'(TILE_ROWS - 1) : cy_i;
    if (by_c == cy_c)      mode_in = M_FLAT_BOTTOM;
    else if (ay_c == by_c) mode_in = M_FLAT_TOP;
    else                   mode_in = M_SPLIT;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Vertex differences and fixed-point numerators
  always_comb begin
    dx_ba   = signed'({1'b0, bx_q}) - signed'({1'b0, ax_q});
    dx_ca   = signed'({1'b0, cx_q}) - signed'({1'b0, ax_q});
    dx_cb   = signed'({1'b0, cx_q}) - signed'({1'b0, bx_q});
    dy_ba   = signed'({1'b0, by_q}) - signed'({1'b0, ay_q});
    dy_ca   = signed'({1'b0, cy_q}) - signed'({1'b0, ay_q});
    dy_cb   = signed'({1'b0, cy_q}) - signed'({1'b0, by_q});
    q_ba    = NUMW'(dx_ba) <<< FRACTION_BITS;
    q_ca    = NUMW'(dx_ca) <<< FRACTION_BITS;
    q_cb    = NUMW'(dx_cb) <<< FRACTION_BITS;
    q_prod  = NUMW'(prod_q) <<< FRACTION_BITS;
    q_low_r = q_ca - off_q;
  end

  // Division operands per sequencer step
  always_comb begin
    div_num   = '0;
    div_den   = '0;
    div_state = 1'b0;
    unique case (state_q)
      S_OFF: begin
        div_num = q_prod; div_den = dy_ca; div_state = 1'b1;
      end
      S_L1: begin
        div_state = 1'b1;
        if (mode_q == M_FLAT_TOP) begin
          div_num = q_ca; div_den = dy_ca;
        end else begin
          div_num = q_ba; div_den = dy_ba;
        end
      end
      S_R1: begin
        div_state = 1'b1;
        unique case (mode_q)
          M_FLAT_BOTTOM: begin div_num = q_ca;  div_den = dy_ca; end
          M_FLAT_TOP:    begin div_num = q_cb;  div_den = dy_cb; end
          default:       begin div_num = off_q; div_den = dy_ba; end
        endcase
      end
      S_L2: begin
        div_num = q_cb; div_den = dy_cb; div_state = 1'b1;
      end
      S_R2: begin
        div_num = q_low_r; div_den = dy_cb; div_state = 1'b1;
      end
      default: ;
    endcase
  end

  assign div_start = div_state && !issued_q;

  // Walk hand-off
  always_comb begin
    walk_ctl            = '0;
    walk_ctl.paint      = paint_q;
    walk_ctl.final_walk = 1'b1;
    if (state_q == S_W1) begin
      walk_ctl.load       = !issued_q;
      walk_ctl.upward     = (mode_q == M_FLAT_TOP);
      walk_ctl.row_first  = (mode_q == M_FLAT_TOP) ? cy_q : ay_q;
      walk_ctl.row_last   = (mode_q == M_FLAT_TOP) ? ay_q : by_q;
      walk_ctl.x_first    = (mode_q == M_FLAT_TOP) ? cx_q : ax_q;
      // the upper half is final only when the lower half is empty
      walk_ctl.final_walk = (mode_q != M_SPLIT) || (cy_q < by_q);
    end else if (state_q == S_W2) begin
      walk_ctl.load      = !issued_q;
      walk_ctl.upward    = 1'b1;
      walk_ctl.row_first = cy_q;
      walk_ctl.row_last  = by_q;
      walk_ctl.x_first   = cx_q;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    unique case (state_q)
      S_IDLE: begin
        issued_d = 1'b0;
        if (accept && fill_i) begin
          state_d = (mode_in == M_SPLIT) ? S_MUL : S_L1;
        end
      end
      S_MUL: state_d = S_OFF;
      S_OFF, S_L1, S_R1, S_L2, S_R2: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (div_done) begin
          issued_d = 1'b0;
          unique case (state_q)
            S_OFF:   state_d = S_L1;
            S_L1:    state_d = S_R1;
            S_R1:    state_d = S_W1;
            S_L2:    state_d = S_R2;
            default: state_d = S_W2;
          endcase
        end
      end
      S_W1, S_W2: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (!sg_busy) begin
          issued_d = 1'b0;
          state_d  = (state_q == S_W1 && mode_q == M_SPLIT) ? S_L2 : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Request registers, split product and division results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q    <= ax_c;
      bx_q    <= bx_c;
      cx_q    <= cx_c;
      ay_q    <= ay_c;
      by_q    <= by_c;
      cy_q    <= cy_c;
      paint_q <= paint_i;
      mode_q  <= mode_in;
    end
    prod_q <= PRW'(dy_ba * dx_ca);
    if (div_done) begin
      unique case (state_q)
        S_OFF:      off_q     <= div_quo;
        S_L1, S_L2: slope_l_q <= div_quo;
        default:    slope_r_q <= div_quo;
      endcase
    end
  end

  ftsr_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ftsr_span_gen #(
    .TILE_COLUMNS  (TILE_COLUMNS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_span_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (walk_ctl),
    .slope_l_i     (slope_l_q),
    .slope_r_i     (slope_r_q),
    .busy_o        (sg_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_o         (row_o),
    .x_start_o     (x_start_o),
    .x_end_o       (x_end_o),
    .span_colour_o (span_colour_o),
    .last_o        (last_o)
  );

  // A division result only arrives in a division step
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_OFF || state_q == S_L1 || state_q == S_R1 ||
                  state_q == S_L2 || state_q == S_R2))
    else $error("division result outside a division step");

  // Walks are only handed off in walk steps
  a_load_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_ctl.load |-> (state_q == S_W1 || state_q == S_W2))
    else $error("walk load outside a walk step");

  // Ready for a request only once the previous walk is finished
  a_idle_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sg_busy) else $error("accepting while a walk is running");

endmodule
